### hw/rtl/tps_pkg.sv
// ----------------------------------------------------------------------------
// tps_pkg
// Shared types and codes of the timepoint prefetch scheduler: command,
// outcome and status codes, register indexes, table entry layout and the
// command and status bundles between controller and datapath.
// ----------------------------------------------------------------------------
package tps_pkg;

   // host commands
   localparam logic [2:0] CMD_SEEK       = 3'd0;
   localparam logic [2:0] CMD_PICK       = 3'd1;
   localparam logic [2:0] CMD_ISSUE      = 3'd2;
   localparam logic [2:0] CMD_PF_DONE    = 3'd3;
   localparam logic [2:0] CMD_INT_DONE   = 3'd4;
   localparam logic [2:0] CMD_EVICT_RAM  = 3'd5;
   localparam logic [2:0] CMD_EVICT_DISK = 3'd6;
   localparam logic [2:0] CMD_CANCEL     = 3'd7;

   // outcome codes
   localparam logic [1:0] OC_OK     = 2'd0;
   localparam logic [1:0] OC_DISK   = 2'd1;
   localparam logic [1:0] OC_SUBMIT = 2'd2;
   localparam logic [1:0] OC_FAIL   = 2'd3;

   // cache status codes
   localparam logic [2:0] ST_NONE    = 3'd0;
   localparam logic [2:0] ST_QUEUED  = 3'd1;
   localparam logic [2:0] ST_LOADING = 3'd2;
   localparam logic [2:0] ST_RAM     = 3'd3;
   localparam logic [2:0] ST_DISK    = 3'd4;
   localparam logic [2:0] ST_FAILED  = 3'd5;

   // register indexes
   localparam logic [2:0] REG_FIRST_TIME    = 3'd0;
   localparam logic [2:0] REG_LAST_TIME     = 3'd1;
   localparam logic [2:0] REG_PF_ENABLE     = 3'd2;
   localparam logic [2:0] REG_WRAP          = 3'd3;
   localparam logic [2:0] REG_HIST_MARGIN   = 3'd4;
   localparam logic [2:0] REG_RAM_BUDGET    = 3'd5;
   localparam logic [2:0] REG_DISK_BUDGET   = 3'd6;
   localparam logic [2:0] REG_MAX_IN_FLIGHT = 3'd7;

   // throttle pre-check result
   localparam logic [1:0] PRE_NONE  = 2'd0;
   localparam logic [1:0] PRE_ANY   = 2'd1;
   localparam logic [1:0] PRE_COUNT = 2'd2;

   // table walk kinds
   localparam logic [1:0] WALK_COUNT  = 2'd0;
   localparam logic [1:0] WALK_MEM    = 2'd1;
   localparam logic [1:0] WALK_DISK   = 2'd2;
   localparam logic [1:0] WALK_CANCEL = 2'd3;

   // one table entry
   typedef struct packed {
      logic [2:0] st;   // cache status
      logic       fl;   // in flight
      logic       wo;   // warm only
      logic       rf;   // warm refused
   } ent_type;

   // controller -> datapath
   typedef struct packed {
      logic       capture;
      logic       ev_update;
      logic       len1;
      logic       len2;
      logic       walk_start;
      logic [1:0] walk_kind;
      logic       pick_write;
      logic       idle_wr;
      logic       idle_val;
      logic       out_load;
   } ctrl_cmd_type;

   // datapath -> controller
   typedef struct packed {
      logic       clear_busy;
      logic [2:0] cmd_code;
      logic       series_valid;
      logic       ifc_zero;
      logic [1:0] pre;
      logic       walk_hit;
      logic       walk_done;
      logic       count_any;
      logic       out_free;
   } dp_sts_type;

endpackage

### hw/rtl/tps_ctrl.sv
// ----------------------------------------------------------------------------
// tps_ctrl
// Sequencer of the scheduler: dispatches one beat, runs the event update,
// the cancel sweep and the throttle / window scans, then hands the result
// to the output register.
// ----------------------------------------------------------------------------
module tps_ctrl (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  tps_pkg::dp_sts_type   sts,
   output tps_pkg::ctrl_cmd_type cmd
);

   localparam logic [3:0] S_IDLE   = 4'd0;
   localparam logic [3:0] S_DISP   = 4'd1;
   localparam logic [3:0] S_EVUPD  = 4'd2;
   localparam logic [3:0] S_CANCEL = 4'd3;
   localparam logic [3:0] S_LEN    = 4'd4;
   localparam logic [3:0] S_LEN2   = 4'd5;
   localparam logic [3:0] S_CNT    = 4'd6;
   localparam logic [3:0] S_MEM    = 4'd7;
   localparam logic [3:0] S_DSK    = 4'd8;
   localparam logic [3:0] S_PWR    = 4'd9;
   localparam logic [3:0] S_OUT    = 4'd10;

   logic [3:0] state_ff, state_in;
   logic       pick_ff, pick_in;   // scan serves a pick, not the idle flag

   assign req_ready = (state_ff == S_IDLE) && !sts.clear_busy;

   // next state and commands
   always_comb begin
      state_in = state_ff;
      pick_in  = pick_ff;
      cmd      = '0;
      case (state_ff)
         S_IDLE: begin
            if (req_valid && !sts.clear_busy) begin
               cmd.capture = 1'b1;
               state_in    = S_DISP;
            end
         end
         S_DISP: begin
            pick_in = 1'b0;
            if (sts.cmd_code == tps_pkg::CMD_PICK) begin
               pick_in  = 1'b1;
               state_in = S_LEN;
            end else if (sts.cmd_code == tps_pkg::CMD_CANCEL) begin
               if (sts.series_valid) begin
                  cmd.walk_start = 1'b1;
                  cmd.walk_kind  = tps_pkg::WALK_CANCEL;
                  state_in       = S_CANCEL;
               end else begin
                  state_in = S_LEN;
               end
            end else begin
               // entry read is in flight this cycle
               state_in = S_EVUPD;
            end
         end
         S_EVUPD: begin
            cmd.ev_update = 1'b1;
            state_in      = S_LEN;
         end
         S_CANCEL: begin
            if (sts.walk_done) state_in = S_LEN;
         end
         S_LEN: begin
            if (!pick_ff && !sts.ifc_zero) begin
               cmd.idle_wr  = 1'b1;
               cmd.idle_val = 1'b0;
               state_in     = S_OUT;
            end else begin
               cmd.len1 = 1'b1;
               state_in = S_LEN2;
            end
         end
         S_LEN2: begin
            cmd.len2 = 1'b1;
            if (sts.pre == tps_pkg::PRE_NONE) begin
               cmd.idle_wr  = 1'b1;
               cmd.idle_val = pick_ff ? sts.ifc_zero : 1'b1;
               state_in     = S_OUT;
            end else if (sts.pre == tps_pkg::PRE_ANY) begin
               cmd.walk_start = 1'b1;
               cmd.walk_kind  = tps_pkg::WALK_MEM;
               state_in       = S_MEM;
            end else begin
               cmd.walk_start = 1'b1;
               cmd.walk_kind  = tps_pkg::WALK_COUNT;
               state_in       = S_CNT;
            end
         end
         S_CNT: begin
            if (sts.walk_done) begin
               cmd.walk_start = 1'b1;
               if (sts.count_any) begin
                  cmd.walk_kind = tps_pkg::WALK_MEM;
                  state_in      = S_MEM;
               end else begin
                  cmd.walk_kind = tps_pkg::WALK_DISK;
                  state_in      = S_DSK;
               end
            end
         end
         S_MEM, S_DSK: begin
            if (sts.walk_hit) begin
               if (pick_ff) begin
                  state_in = S_PWR;
               end else begin
                  cmd.idle_wr  = 1'b1;
                  cmd.idle_val = 1'b0;
                  state_in     = S_OUT;
               end
            end else if (sts.walk_done) begin
               if (state_ff == S_MEM) begin
                  cmd.walk_start = 1'b1;
                  cmd.walk_kind  = tps_pkg::WALK_DISK;
                  state_in       = S_DSK;
               end else begin
                  cmd.idle_wr  = 1'b1;
                  cmd.idle_val = pick_ff ? sts.ifc_zero : 1'b1;
                  state_in     = S_OUT;
               end
            end
         end
         S_PWR: begin
            // chosen entry goes queued, then rescan for the idle flag
            cmd.pick_write = 1'b1;
            pick_in        = 1'b0;
            state_in       = S_LEN;
         end
         S_OUT: begin
            if (sts.out_free) begin
               cmd.out_load = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   // state registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         pick_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         pick_ff  <= pick_in;
      end
   end

endmodule

### hw/rtl/tps_datapath.sv
// ----------------------------------------------------------------------------
// tps_datapath
// Registers, status table memory, table clearing pass, event update logic,
// window length math, the table walk engine and the output register.
// ----------------------------------------------------------------------------
module tps_datapath #(
   parameter int MAX_TIMEPOINTS = 1024
) (
   input  logic                  clock,
   input  logic                  reset,
   // input beat payload
   input  logic [2:0]            req_cmd,
   input  logic [31:0]           req_time_req,
   input  logic [1:0]            req_outcome,
   input  logic                  req_on_disk,
   // register writes
   input  logic                  csr_we,
   input  logic [2:0]            csr_index,
   input  logic [31:0]           csr_wdata,
   // result beat
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output logic                  rsp_found,
   output logic [31:0]           rsp_chosen_time,
   output logic                  rsp_warm_only,
   output logic [2:0]            rsp_new_status,
   output logic                  rsp_status_changed,
   output logic                  rsp_idle,
   // control
   input  tps_pkg::ctrl_cmd_type cmd,
   output tps_pkg::dp_sts_type   sts
);

   localparam int OW = $clog2(MAX_TIMEPOINTS);        // offset bits
   localparam int CW = $clog2(MAX_TIMEPOINTS + 1);    // count bits
   localparam int LW = ((CW > 16) ? CW : 16) + 2;     // length math bits
   localparam int WW = CW + 8;                        // wanted-frames bits

   // configuration
   logic [31:0] first_ff, last_ff;
   logic        pe_ff, wrap_ff;
   logic [9:0]  hm_ff;
   logic [15:0] rb_ff, db_ff;
   logic [6:0]  mif_ff;

   // control state
   logic          sv_ff, ip_ff, fsk_ff;
   logic [6:0]    ifc_ff;
   logic [OW-1:0] cur_ff;
   logic          clr_busy_ff;
   logic [OW-1:0] clr_cnt_ff;

   // derived series extent
   logic [31:0]   eff_last_ff;
   logic [CW-1:0] span_ff;

   // captured beat
   logic [2:0]    cmd_ff;
   logic [31:0]   t_ff;
   logic [OW-1:0] off_ff;
   logic          inr_ff;
   logic [1:0]    oc_ff;
   logic          disk_ff;

   // result staging and output register
   logic        res_found_ff, res_warm_ff, res_changed_ff, res_idle_ff;
   logic [31:0] res_time_ff;
   logic [2:0]  res_ns_ff;
   logic        rsp_valid_ff;

   // scan state
   logic [CW-1:0] n_ff, d_ff;
   logic [1:0]    pre_ff;
   logic [WW-1:0] wanted_ff;

   // walk engine
   logic [OW-1:0] wk_ptr_ff, tag_ff, hit_off_ff;
   logic [CW-1:0] wk_rem_ff;
   logic [1:0]    wk_kind_ff;
   logic          pend_ff, hit_warm_ff;
   tps_pkg::ent_type hit_ent_ff;

   // table memory
   tps_pkg::ent_type mem [MAX_TIMEPOINTS];
   tps_pkg::ent_type rdata_ff;
   logic             wr_en;
   logic [OW-1:0]    wr_addr, rd_addr;
   tps_pkg::ent_type wr_data;

   // ------------------------------------------------------------------
   // series extent, registered
   logic [32:0]   cap33, el33;
   logic [32:0]   span33;
   always_comb begin
      cap33 = {1'b0, first_ff} + 33'(MAX_TIMEPOINTS - 1);
      el33  = ({1'b0, last_ff} > cap33) ? cap33 : {1'b0, last_ff};
      if (el33 < {1'b0, first_ff}) el33 = {1'b0, first_ff};
      span33 = el33 - {1'b0, first_ff} + 33'd1;
   end

   // ------------------------------------------------------------------
   // beat capture: range check, seek clamp
   logic [31:0] cap_t, cap_d;
   logic        cap_inr, t_ge, t_le;
   always_comb begin
      t_ge    = req_time_req >= first_ff;
      t_le    = req_time_req <= eff_last_ff;
      cap_t   = req_time_req;
      cap_inr = sv_ff && t_ge && t_le;
      if (req_cmd == tps_pkg::CMD_SEEK && sv_ff) begin
         cap_inr = 1'b1;
         if (!t_ge)      cap_t = first_ff;
         else if (!t_le) cap_t = eff_last_ff;
      end
      cap_d = cap_t - first_ff;
   end

   // ------------------------------------------------------------------
   // event update on the read entry
   tps_pkg::ent_type ev_old, ev_new;
   logic ev_found, ev_inc, ev_dec, ev_ip_set, ev_ip_clr, ev_cur_set, ev_fsk_set;
   always_comb begin
      ev_old     = rdata_ff;
      ev_new     = rdata_ff;
      ev_found   = 1'b0;
      ev_inc     = 1'b0;
      ev_dec     = 1'b0;
      ev_ip_set  = 1'b0;
      ev_ip_clr  = 1'b0;
      ev_cur_set = 1'b0;
      ev_fsk_set = 1'b0;
      case (cmd_ff)
         tps_pkg::CMD_SEEK: begin
            if (inr_ff) begin
               ev_found   = 1'b1;
               ev_ip_set  = 1'b1;
               ev_cur_set = 1'b1;
               if (ev_old.fl) begin
                  ev_new.fl = 1'b0;
                  ev_dec    = 1'b1;
               end
               ev_new.wo = 1'b0;
               if (ev_old.st != tps_pkg::ST_RAM) ev_new.st = tps_pkg::ST_LOADING;
            end
         end
         tps_pkg::CMD_ISSUE: begin
            if (inr_ff && ev_old.st == tps_pkg::ST_QUEUED) begin
               ev_found = 1'b1;
               if (oc_ff == tps_pkg::OC_SUBMIT) begin
                  if (!ev_old.fl) begin
                     ev_new.fl = 1'b1;
                     ev_inc    = 1'b1;
                  end
                  ev_new.st = tps_pkg::ST_LOADING;
               end else begin
                  ev_new.wo = 1'b0;
                  case (oc_ff)
                     tps_pkg::OC_OK:   ev_new.st = tps_pkg::ST_RAM;
                     tps_pkg::OC_DISK: ev_new.st = tps_pkg::ST_DISK;
                     default:          ev_new.st = tps_pkg::ST_FAILED;
                  endcase
               end
            end
         end
         tps_pkg::CMD_PF_DONE: begin
            if (inr_ff && ev_old.fl) begin
               ev_found  = 1'b1;
               ev_new.fl = 1'b0;
               ev_dec    = 1'b1;
               case (oc_ff)
                  tps_pkg::OC_OK: begin
                     ev_fsk_set = 1'b1;
                     ev_new.st  = ev_old.wo ? tps_pkg::ST_DISK : tps_pkg::ST_RAM;
                  end
                  tps_pkg::OC_DISK: begin
                     ev_new.rf = 1'b1;
                     ev_new.st = tps_pkg::ST_NONE;
                  end
                  tps_pkg::OC_SUBMIT: ev_new.st = tps_pkg::ST_NONE;
                  default:            ev_new.st = tps_pkg::ST_FAILED;
               endcase
               ev_new.wo = 1'b0;
            end
         end
         tps_pkg::CMD_INT_DONE: begin
            if (inr_ff) begin
               ev_found = 1'b1;
               if (off_ff == cur_ff) ev_ip_clr = 1'b1;
               case (oc_ff)
                  tps_pkg::OC_OK: begin
                     ev_fsk_set = 1'b1;
                     ev_new.st  = tps_pkg::ST_RAM;
                  end
                  tps_pkg::OC_SUBMIT: ev_new.st = tps_pkg::ST_NONE;
                  default:            ev_new.st = tps_pkg::ST_FAILED;
               endcase
            end
         end
         tps_pkg::CMD_EVICT_RAM: begin
            if (inr_ff && ev_old.st == tps_pkg::ST_RAM) begin
               ev_found  = 1'b1;
               ev_new.st = disk_ff ? tps_pkg::ST_DISK : tps_pkg::ST_NONE;
            end
         end
         tps_pkg::CMD_EVICT_DISK: begin
            if (inr_ff && ev_old.st == tps_pkg::ST_DISK) begin
               ev_found  = 1'b1;
               ev_new.st = tps_pkg::ST_NONE;
            end
         end
         default: ev_found = 1'b0;
      endcase
   end

   // ------------------------------------------------------------------
   // window lengths and throttle pre-check
   logic [LW-1:0] span_l, cur_l, n_l, d_l, steps_m, resv, capm, lim_l;
   logic [LW-1:0] steps_d, capd, end_d, len_m, len_d, pos_mem, pos_dsk;
   logic [6:0]    mif_lim;
   logic [1:0]    pre_calc;
   always_comb begin
      span_l = LW'(span_ff);
      cur_l  = LW'(cur_ff);
      n_l    = LW'(n_ff);
      lim_l  = span_l - LW'(1) - cur_l;

      // forward memory window
      steps_m = span_l - LW'(1);
      resv    = LW'(hm_ff) + LW'(1);
      capm    = (LW'(rb_ff) > resv) ? (LW'(rb_ff) - resv) : LW'(1);
      if (fsk_ff && capm < steps_m) steps_m = capm;
      if (!sv_ff || span_l <= LW'(1))       len_m = '0;
      else if (wrap_ff)                     len_m = steps_m;
      else if (cur_l + LW'(1) >= span_l)    len_m = '0;
      else                                  len_m = (steps_m < lim_l) ? steps_m : lim_l;

      // disk-warm window beyond it
      capd    = (LW'(db_ff) > n_l + LW'(1)) ? (LW'(db_ff) - n_l - LW'(1)) : '0;
      steps_d = span_l - LW'(1) - n_l;
      if (capd < steps_d) steps_d = capd;
      end_d   = n_l + steps_d;
      if (end_d > lim_l) end_d = lim_l;
      if (!sv_ff || db_ff == '0 || span_l <= LW'(1) || !fsk_ff) len_d = '0;
      else if (n_l + LW'(1) >= span_l)                         len_d = '0;
      else if (wrap_ff)                                        len_d = steps_d;
      else if (cur_l + LW'(1) >= span_l)                       len_d = '0;
      else                                 len_d = (end_d > n_l) ? (end_d - n_l) : '0;

      // throttle
      mif_lim = (mif_ff == '0) ? 7'd1 : mif_ff;
      if (!sv_ff || !pe_ff || ip_ff || ifc_ff >= mif_lim) pre_calc = tps_pkg::PRE_NONE;
      else if (!fsk_ff) pre_calc = (ifc_ff == '0) ? tps_pkg::PRE_ANY : tps_pkg::PRE_NONE;
      else if (rb_ff == '0) pre_calc = tps_pkg::PRE_NONE;
      else pre_calc = tps_pkg::PRE_COUNT;

      // walk start positions, folded once into the series when wrapping
      pos_mem = cur_l + LW'(1);
      if (wrap_ff && pos_mem >= span_l) pos_mem = pos_mem - span_l;
      pos_dsk = cur_l + n_l + LW'(1);
      if (wrap_ff && pos_dsk >= span_l) pos_dsk = pos_dsk - span_l;
      d_l = LW'(d_ff);
   end

   // ------------------------------------------------------------------
   // walk engine: one read a cycle, data tagged in the next cycle
   logic          walk_match, walk_hit, issuing;
   logic [LW-1:0] ptr_nxt;
   logic          cancel_wr;
   always_comb begin
      case (wk_kind_ff)
         tps_pkg::WALK_MEM:
            walk_match = !rdata_ff.fl &&
                         (rdata_ff.st == tps_pkg::ST_NONE || rdata_ff.st == tps_pkg::ST_DISK);
         tps_pkg::WALK_DISK:
            walk_match = rdata_ff.st == tps_pkg::ST_NONE && !rdata_ff.fl && !rdata_ff.rf;
         default: walk_match = 1'b0;
      endcase
      walk_hit  = pend_ff && walk_match;
      issuing   = (wk_rem_ff != '0) && !walk_hit;
      rd_addr   = issuing ? wk_ptr_ff : off_ff;
      ptr_nxt   = LW'(wk_ptr_ff) + LW'(1);
      if (wrap_ff && ptr_nxt == span_l) ptr_nxt = '0;
      cancel_wr = pend_ff && wk_kind_ff == tps_pkg::WALK_CANCEL &&
                  (rdata_ff.st == tps_pkg::ST_QUEUED || rdata_ff.st == tps_pkg::ST_LOADING);
   end

   // ------------------------------------------------------------------
   // table write port
   tps_pkg::ent_type pick_ent, can_ent;
   always_comb begin
      pick_ent    = hit_ent_ff;
      pick_ent.st = tps_pkg::ST_QUEUED;
      pick_ent.wo = hit_warm_ff;
      can_ent     = rdata_ff;
      can_ent.st  = tps_pkg::ST_NONE;
      wr_en       = 1'b0;
      wr_addr     = off_ff;
      wr_data     = ev_new;
      if (clr_busy_ff) begin
         wr_en   = 1'b1;
         wr_addr = clr_cnt_ff;
         wr_data = '0;
      end else if (cancel_wr) begin
         wr_en   = 1'b1;
         wr_addr = tag_ff;
         wr_data = can_ent;
      end else if (cmd.ev_update && ev_found) begin
         wr_en = 1'b1;
      end else if (cmd.pick_write) begin
         wr_en   = 1'b1;
         wr_addr = hit_off_ff;
         wr_data = pick_ent;
      end
   end

   // table memory
   always_ff @(posedge clock) begin
      if (wr_en) mem[wr_addr] <= wr_data;
      rdata_ff <= mem[rd_addr];
   end

   // ------------------------------------------------------------------
   // control registers
   logic new_series;
   assign new_series = csr_we &&
                       (csr_index == tps_pkg::REG_FIRST_TIME ||
                        csr_index == tps_pkg::REG_LAST_TIME);

   always_ff @(posedge clock) begin
      if (reset) begin
         first_ff    <= '0;
         last_ff     <= '0;
         pe_ff       <= 1'b0;
         wrap_ff     <= 1'b0;
         hm_ff       <= '0;
         rb_ff       <= '0;
         db_ff       <= '0;
         mif_ff      <= 7'd1;
         sv_ff       <= 1'b0;
         ip_ff       <= 1'b0;
         fsk_ff      <= 1'b0;
         ifc_ff      <= '0;
         cur_ff      <= '0;
         clr_busy_ff <= 1'b1;
         clr_cnt_ff  <= '0;
         wk_rem_ff   <= '0;
         pend_ff     <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         // register writes
         if (csr_we) begin
            case (csr_index)
               tps_pkg::REG_FIRST_TIME:    first_ff <= csr_wdata;
               tps_pkg::REG_LAST_TIME:     last_ff  <= csr_wdata;
               tps_pkg::REG_PF_ENABLE:     pe_ff    <= csr_wdata[0];
               tps_pkg::REG_WRAP:          wrap_ff  <= csr_wdata[0];
               tps_pkg::REG_HIST_MARGIN:   hm_ff    <= csr_wdata[9:0];
               tps_pkg::REG_RAM_BUDGET:    rb_ff    <= csr_wdata[15:0];
               tps_pkg::REG_DISK_BUDGET:   db_ff    <= csr_wdata[15:0];
               tps_pkg::REG_MAX_IN_FLIGHT: mif_ff   <= csr_wdata[6:0];
               default:                    sv_ff    <= sv_ff;
            endcase
         end

         // clearing pass
         if (clr_busy_ff) begin
            clr_cnt_ff <= clr_cnt_ff + OW'(1);
            if (clr_cnt_ff == OW'(MAX_TIMEPOINTS - 1)) clr_busy_ff <= 1'b0;
         end

         // event effects on the scalar state
         if (cmd.ev_update) begin
            if (ev_ip_set)  ip_ff  <= 1'b1;
            if (ev_ip_clr)  ip_ff  <= 1'b0;
            if (ev_cur_set) cur_ff <= off_ff;
            if (ev_fsk_set) fsk_ff <= 1'b1;
            if (ev_dec && ifc_ff != '0)      ifc_ff <= ifc_ff - 7'd1;
            else if (ev_inc && ifc_ff != '1) ifc_ff <= ifc_ff + 7'd1;
         end

         // walk engine
         if (cmd.walk_start) begin
            case (cmd.walk_kind)
               tps_pkg::WALK_COUNT: begin
                  wk_ptr_ff <= cur_ff;
                  wk_rem_ff <= n_ff + CW'(1);
               end
               tps_pkg::WALK_MEM: begin
                  wk_ptr_ff <= pos_mem[OW-1:0];
                  wk_rem_ff <= n_ff;
               end
               tps_pkg::WALK_DISK: begin
                  wk_ptr_ff <= pos_dsk[OW-1:0];
                  wk_rem_ff <= d_l[CW-1:0];
               end
               default: begin
                  wk_ptr_ff <= '0;
                  wk_rem_ff <= span_ff;
               end
            endcase
         end else if (walk_hit) begin
            wk_rem_ff <= '0;
         end else if (issuing) begin
            wk_ptr_ff <= ptr_nxt[OW-1:0];
            wk_rem_ff <= wk_rem_ff - CW'(1);
         end
         pend_ff <= issuing;

         // output register
         if (cmd.out_load)   rsp_valid_ff <= 1'b1;
         else if (rsp_ready) rsp_valid_ff <= 1'b0;

         // a new series wipes the table and the per-series state
         if (new_series) begin
            sv_ff       <= 1'b1;
            ip_ff       <= 1'b0;
            fsk_ff      <= 1'b0;
            ifc_ff      <= '0;
            cur_ff      <= '0;
            clr_busy_ff <= 1'b1;
            clr_cnt_ff  <= '0;
         end
      end
   end

   // ------------------------------------------------------------------
   // payload registers
   always_ff @(posedge clock) begin
      eff_last_ff <= el33[31:0];
      span_ff     <= span33[CW-1:0];
      tag_ff      <= rd_addr;

      if (cmd.capture) begin
         cmd_ff  <= req_cmd;
         t_ff    <= cap_t;
         off_ff  <= cap_d[OW-1:0];
         inr_ff  <= cap_inr;
         oc_ff   <= req_outcome;
         disk_ff <= req_on_disk;
         // pick and cancel start from their fixed answers
         res_found_ff   <= (req_cmd == tps_pkg::CMD_CANCEL);
         res_time_ff    <= (req_cmd == tps_pkg::CMD_CANCEL) ? first_ff : '0;
         res_warm_ff    <= 1'b0;
         res_ns_ff      <= tps_pkg::ST_NONE;
         res_changed_ff <= 1'b0;
      end

      if (cmd.ev_update) begin
         res_found_ff   <= ev_found;
         res_time_ff    <= t_ff;
         res_ns_ff      <= inr_ff ? ev_new.st : tps_pkg::ST_NONE;
         res_changed_ff <= ev_found && (ev_new.st != ev_old.st);
      end

      if (cancel_wr) res_changed_ff <= 1'b1;

      if (cmd.pick_write) begin
         res_found_ff   <= 1'b1;
         res_time_ff    <= first_ff + 32'(hit_off_ff);
         res_warm_ff    <= hit_warm_ff;
         res_ns_ff      <= tps_pkg::ST_QUEUED;
         res_changed_ff <= hit_ent_ff.st != tps_pkg::ST_QUEUED;
      end

      if (cmd.idle_wr) res_idle_ff <= cmd.idle_val;

      if (cmd.len1) begin
         n_ff   <= len_m[CW-1:0];
         pre_ff <= pre_calc;
      end
      if (cmd.len2) d_ff <= len_d[CW-1:0];

      // frames wanted in RAM: in flight plus RAM entries of the window
      if (cmd.walk_start) begin
         wanted_ff <= WW'(ifc_ff);
      end else if (pend_ff && wk_kind_ff == tps_pkg::WALK_COUNT &&
                   rdata_ff.st == tps_pkg::ST_RAM) begin
         wanted_ff <= wanted_ff + WW'(1);
      end
      if (cmd.walk_start) wk_kind_ff <= cmd.walk_kind;

      if (walk_hit) begin
         hit_off_ff  <= tag_ff;
         hit_ent_ff  <= rdata_ff;
         hit_warm_ff <= (wk_kind_ff == tps_pkg::WALK_DISK);
      end

      if (cmd.out_load) begin
         rsp_found          <= res_found_ff;
         rsp_chosen_time    <= res_time_ff;
         rsp_warm_only      <= res_warm_ff;
         rsp_new_status     <= res_ns_ff;
         rsp_status_changed <= res_changed_ff;
         rsp_idle           <= res_idle_ff;
      end
   end

   assign rsp_valid = rsp_valid_ff;

   // status to the controller
   always_comb begin
      sts              = '0;
      sts.clear_busy   = clr_busy_ff;
      sts.cmd_code     = cmd_ff;
      sts.series_valid = sv_ff;
      sts.ifc_zero     = (ifc_ff == '0);
      sts.pre          = pre_ff;
      sts.walk_hit     = walk_hit;
      sts.walk_done    = (wk_rem_ff == '0) && !pend_ff;
      sts.count_any    = (wanted_ff < WW'(rb_ff));
      sts.out_free     = !rsp_valid_ff || rsp_ready;
   end

endmodule

### hw/rtl/timepoint_prefetch_scheduler_top.sv
// ----------------------------------------------------------------------------
// timepoint_prefetch_scheduler_top
// Per-timepoint cache status keeper and prefetch picker for one series.
//
//   channel  | ports                         | direction | handshake
//   ---------+-------------------------------+-----------+----------------
//   request  | req_cmd/time_req/outcome/...  | in        | req_valid/ready
//   response | rsp_found/chosen_time/...     | out       | rsp_valid/ready
//   config   | csr_index, csr_wdata          | in        | csr_we
//
// A beat other than a pick that leaves a load in flight skips the window
// scan. Otherwise the idle flag needs a window scan that walks the status
// table one entry per cycle through its single read port; span is at most
// MAX_TIMEPOINTS. A pick scans to choose and, after a hit, once more for
// the idle flag; cancel all first sweeps the series.
// After reset and after each write of first_time or last_time a clearing
// pass over all MAX_TIMEPOINTS entries runs; no request beat is taken meanwhile.
// A result beat waiting on rsp_ready holds the sequencer before the next beat.
// ----------------------------------------------------------------------------
module timepoint_prefetch_scheduler_top #(
   parameter int MAX_TIMEPOINTS = 1024
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [2:0]  req_cmd,
   input  logic [31:0] req_time_req,
   input  logic [1:0]  req_outcome,
   input  logic        req_on_disk,
   input  logic        csr_we,
   input  logic [2:0]  csr_index,
   input  logic [31:0] csr_wdata,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic        rsp_found,
   output logic [31:0] rsp_chosen_time,
   output logic        rsp_warm_only,
   output logic [2:0]  rsp_new_status,
   output logic        rsp_status_changed,
   output logic        rsp_idle
);

   tps_pkg::ctrl_cmd_type cmd;
   tps_pkg::dp_sts_type   sts;

   // sequencer
   tps_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .sts       (sts),
      .cmd       (cmd)
   );

   // table, registers and scan engine
   tps_datapath #(
      .MAX_TIMEPOINTS (MAX_TIMEPOINTS)
   ) u_dp (
      .clock              (clock),
      .reset              (reset),
      .req_cmd            (req_cmd),
      .req_time_req       (req_time_req),
      .req_outcome        (req_outcome),
      .req_on_disk        (req_on_disk),
      .csr_we             (csr_we),
      .csr_index          (csr_index),
      .csr_wdata          (csr_wdata),
      .rsp_valid          (rsp_valid),
      .rsp_ready          (rsp_ready),
      .rsp_found          (rsp_found),
      .rsp_chosen_time    (rsp_chosen_time),
      .rsp_warm_only      (rsp_warm_only),
      .rsp_new_status     (rsp_new_status),
      .rsp_status_changed (rsp_status_changed),
      .rsp_idle           (rsp_idle),
      .cmd                (cmd),
      .sts                (sts)
   );

endmodule

### test/timepoint_prefetch_scheduler_top_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// timepoint_prefetch_scheduler_top_test
// Self-checking bench: beats are generated from the live cache table so that
// issue outcomes, completions and evictions hit real entries. Every
// accepted beat runs through a cycle-free model of the table, and each
// response beat is compared field by field against it, over several series.
// ----------------------------------------------------------------------------
module timepoint_prefetch_scheduler_top_test;

   localparam int DEPTH = 1024;
   localparam longint CYCLE_LIMIT = 6000000;

   typedef longint unsigned u64_type;
   typedef enum int {GRANT_NONE, GRANT_ANY, GRANT_WARM} grant_type;

   typedef struct {
      logic [2:0]  cmd;
      logic [31:0] t;
      logic [1:0]  oc;
      logic        disk;
   } beat_type;

   typedef struct {
      logic        found;
      logic [31:0] t;
      logic        warm;
      logic [2:0]  ns;
      logic        chg;
      logic        idle;
   } rsp_type;

   logic        clock = 0;
   logic        reset = 1;
   logic        req_valid = 0;
   logic        req_ready;
   logic [2:0]  req_cmd = '0;
   logic [31:0] req_time_req = '0;
   logic [1:0]  req_outcome = '0;
   logic        req_on_disk = 0;
   logic        csr_we = 0;
   logic [2:0]  csr_index = '0;
   logic [31:0] csr_wdata = '0;
   logic        rsp_valid;
   logic        rsp_ready = 0;
   logic        rsp_found;
   logic [31:0] rsp_chosen_time;
   logic        rsp_warm_only;
   logic [2:0]  rsp_new_status;
   logic        rsp_status_changed;
   logic        rsp_idle;

   timepoint_prefetch_scheduler_top #(.MAX_TIMEPOINTS(DEPTH)) u_top (.*);

   always #5 clock = ~clock;

   // ---------------------------------------------------------------- model
   logic [31:0] cfg_first, cfg_last;
   logic        cfg_pf, cfg_wrap;
   logic [9:0]  cfg_hist;
   logic [15:0] cfg_ram, cfg_disk;
   logic [6:0]  cfg_mif;

   logic [2:0]  st_tab [DEPTH];
   bit          fl_m [DEPTH];
   bit          wo_m [DEPTH];
   bit          rf_m [DEPTH];
   int unsigned fl_cnt, cur_off;
   bit          int_pend, fsize_known, series_on;

   function automatic u64_type span_len();
      u64_type f, l, cap;
      f = u64_type'(cfg_first);
      l = u64_type'(cfg_last);
      cap = f + u64_type'(DEPTH) - 1;
      if (l > cap) l = cap;
      if (l < f) l = f;
      return l - f + 1;
   endfunction

   function automatic bit offset_of(logic [31:0] t, output int unsigned o);
      u64_type d;
      o = 0;
      if (!series_on || t < cfg_first) return 1'b0;
      d = u64_type'(t) - u64_type'(cfg_first);
      if (d >= span_len() || d >= u64_type'(DEPTH)) return 1'b0;
      o = 32'(d);
      return 1'b1;
   endfunction

   function automatic int unsigned pos_off(u64_type i);
      u64_type p;
      p = u64_type'(cur_off) + i;
      if (cfg_wrap) p = p % span_len();
      return p[31:0];
   endfunction

   function automatic u64_type nonwrap_len(u64_type start, u64_type steps);
      u64_type sp, lim, stop;
      sp = span_len();
      stop = start + steps;
      if (cfg_wrap) return steps;
      if (u64_type'(cur_off) + 1 >= sp) return 0;
      lim = sp - 1 - u64_type'(cur_off);
      if (stop > lim) stop = lim;
      return stop > start ? stop - start : 0;
   endfunction

   function automatic u64_type mem_len();
      u64_type sp, steps, resv, cap;
      sp = span_len();
      if (!series_on || sp <= 1) return 0;
      steps = sp - 1;
      if (fsize_known) begin
         resv = 1 + u64_type'(cfg_hist);
         cap = u64_type'(cfg_ram) > resv ? u64_type'(cfg_ram) - resv : 1;
         if (cap < steps) steps = cap;
      end
      return nonwrap_len(0, steps);
   endfunction

   function automatic u64_type disk_len(u64_type fwd);
      u64_type sp, cap, steps;
      sp = span_len();
      if (!series_on || cfg_disk == 0 || sp <= 1 || !fsize_known) return 0;
      if (fwd + 1 >= sp) return 0;
      cap = u64_type'(cfg_disk) > fwd + 1 ? u64_type'(cfg_disk) - (fwd + 1) : 0;
      steps = sp - 1 - fwd;
      if (cap < steps) steps = cap;
      return nonwrap_len(fwd, steps);
   endfunction

   function automatic logic [2:0] st_at(int unsigned o);
      return o < DEPTH ? st_tab[o] : tps_pkg::ST_NONE;
   endfunction

   function automatic grant_type throttle();
      int unsigned lim;
      u64_type wanted, n;
      lim = cfg_mif != 0 ? 32'(cfg_mif) : 32'd1;
      if (!series_on || !cfg_pf || int_pend) return GRANT_NONE;
      if (fl_cnt >= lim) return GRANT_NONE;
      if (!fsize_known) return fl_cnt == 0 ? GRANT_ANY : GRANT_NONE;
      if (cfg_ram == 0) return GRANT_NONE;
      wanted = u64_type'(fl_cnt);
      if (st_at(cur_off) == tps_pkg::ST_RAM) wanted++;
      n = mem_len();
      for (u64_type i = 1; i <= n; i++)
         if (st_at(pos_off(i)) == tps_pkg::ST_RAM) wanted++;
      return wanted < u64_type'(cfg_ram) ? GRANT_ANY : GRANT_WARM;
   endfunction

   // nearest eligible entry: memory window first, then the disk-warm window
   function automatic bit window_scan(output int unsigned o, output bit warm);
      grant_type g;
      u64_type n, d;
      int unsigned p;
      logic [2:0] s;
      g = throttle();
      o = 0;
      warm = 1'b0;
      if (g == GRANT_NONE) return 1'b0;
      n = mem_len();
      if (g == GRANT_ANY) begin
         for (u64_type i = 1; i <= n; i++) begin
            p = pos_off(i);
            s = st_at(p);
            if (p >= DEPTH || fl_m[p]) continue;
            if (s == tps_pkg::ST_NONE || s == tps_pkg::ST_DISK) begin
               o = p;
               return 1'b1;
            end
         end
      end
      d = disk_len(n);
      for (u64_type i = n + 1; i <= n + d; i++) begin
         p = pos_off(i);
         if (p >= DEPTH || st_at(p) != tps_pkg::ST_NONE) continue;
         if (fl_m[p] || rf_m[p]) continue;
         o = p;
         warm = 1'b1;
         return 1'b1;
      end
      return 1'b0;
   endfunction

   function automatic bit set_st(int unsigned o, logic [2:0] s);
      if (o >= DEPTH || st_tab[o] == s) return 1'b0;
      st_tab[o] = s;
      return 1'b1;
   endfunction

   function automatic void drop_flight(int unsigned o);
      if (o < DEPTH && fl_m[o]) begin
         fl_m[o] = 1'b0;
         if (fl_cnt != 0) fl_cnt--;
      end
   endfunction

   function automatic void clear_series();
      for (int i = 0; i < DEPTH; i++) begin
         st_tab[i] = tps_pkg::ST_NONE;
         fl_m[i] = 1'b0;
         wo_m[i] = 1'b0;
         rf_m[i] = 1'b0;
      end
      fl_cnt = 0;
      cur_off = 0;
      int_pend = 1'b0;
      fsize_known = 1'b0;
   endfunction

   function automatic void model_write(logic [2:0] idx, logic [31:0] v);
      case (idx)
         tps_pkg::REG_FIRST_TIME: begin
            cfg_first = v;
            clear_series();
            series_on = 1'b1;
         end
         tps_pkg::REG_LAST_TIME: begin
            cfg_last = v;
            clear_series();
            series_on = 1'b1;
         end
         tps_pkg::REG_PF_ENABLE:     cfg_pf = v[0];
         tps_pkg::REG_WRAP:          cfg_wrap = v[0];
         tps_pkg::REG_HIST_MARGIN:   cfg_hist = v[9:0];
         tps_pkg::REG_RAM_BUDGET:    cfg_ram = v[15:0];
         tps_pkg::REG_DISK_BUDGET:   cfg_disk = v[15:0];
         tps_pkg::REG_MAX_IN_FLIGHT: cfg_mif = v[6:0];
         default: ;
      endcase
   endfunction

   // apply one event beat to the table, return the response it causes
   function automatic rsp_type schedule_event(beat_type b);
      rsp_type r;
      int unsigned o, po;
      bit inr, pw;
      logic [31:0] t;
      u64_type sp;
      r = '{default: 0};
      t = b.t;
      inr = offset_of(t, o);
      case (b.cmd)
         tps_pkg::CMD_SEEK: begin
            if (series_on) begin
               if (t < cfg_first) t = cfg_first;
               if (u64_type'(t) - u64_type'(cfg_first) >= span_len())
                  t = 32'(u64_type'(cfg_first) + span_len() - 1);
               inr = offset_of(t, o);
               if (inr) begin
                  r.found = 1'b1;
                  int_pend = 1'b1;
                  cur_off = o;
                  drop_flight(o);
                  wo_m[o] = 1'b0;
                  if (st_tab[o] != tps_pkg::ST_RAM) r.chg = set_st(o, tps_pkg::ST_LOADING);
               end
            end
         end
         tps_pkg::CMD_PICK: begin
            inr = 1'b0;
            t = '0;
            if (window_scan(o, pw)) begin
               r.found = 1'b1;
               r.warm = pw;
               inr = 1'b1;
               t = cfg_first + o;
               r.chg = set_st(o, tps_pkg::ST_QUEUED);
               wo_m[o] = pw;
            end
         end
         tps_pkg::CMD_ISSUE: begin
            if (inr && st_tab[o] == tps_pkg::ST_QUEUED) begin
               r.found = 1'b1;
               if (b.oc == tps_pkg::OC_SUBMIT) begin
                  if (!fl_m[o]) begin
                     fl_m[o] = 1'b1;
                     if (fl_cnt < 127) fl_cnt++;
                  end
                  r.chg = set_st(o, tps_pkg::ST_LOADING);
               end else begin
                  wo_m[o] = 1'b0;
                  r.chg = set_st(o, b.oc == tps_pkg::OC_OK ? tps_pkg::ST_RAM :
                                    b.oc == tps_pkg::OC_DISK ? tps_pkg::ST_DISK :
                                    tps_pkg::ST_FAILED);
               end
            end
         end
         tps_pkg::CMD_PF_DONE: begin
            if (inr && fl_m[o]) begin
               r.found = 1'b1;
               drop_flight(o);
               if (b.oc == tps_pkg::OC_OK) begin
                  fsize_known = 1'b1;
                  r.chg = set_st(o, wo_m[o] ? tps_pkg::ST_DISK : tps_pkg::ST_RAM);
               end else if (b.oc == tps_pkg::OC_DISK) begin
                  rf_m[o] = 1'b1;
                  r.chg = set_st(o, tps_pkg::ST_NONE);
               end else begin
                  r.chg = set_st(o, b.oc == tps_pkg::OC_SUBMIT ? tps_pkg::ST_NONE :
                                    tps_pkg::ST_FAILED);
               end
               wo_m[o] = 1'b0;
            end
         end
         tps_pkg::CMD_INT_DONE: begin
            if (inr) begin
               r.found = 1'b1;
               if (o == cur_off) int_pend = 1'b0;
               if (b.oc == tps_pkg::OC_OK) begin
                  fsize_known = 1'b1;
                  r.chg = set_st(o, tps_pkg::ST_RAM);
               end else begin
                  r.chg = set_st(o, b.oc == tps_pkg::OC_SUBMIT ? tps_pkg::ST_NONE :
                                    tps_pkg::ST_FAILED);
               end
            end
         end
         tps_pkg::CMD_EVICT_RAM: begin
            if (inr && st_tab[o] == tps_pkg::ST_RAM) begin
               r.found = 1'b1;
               r.chg = set_st(o, b.disk ? tps_pkg::ST_DISK : tps_pkg::ST_NONE);
            end
         end
         tps_pkg::CMD_EVICT_DISK: begin
            if (inr && st_tab[o] == tps_pkg::ST_DISK) begin
               r.found = 1'b1;
               r.chg = set_st(o, tps_pkg::ST_NONE);
            end
         end
         default: begin
            r.found = 1'b1;
            inr = 1'b0;
            t = cfg_first;
            if (series_on) begin
               sp = span_len();
               for (int i = 0; i < sp && i < DEPTH; i++)
                  if (st_tab[i] == tps_pkg::ST_QUEUED || st_tab[i] == tps_pkg::ST_LOADING) begin
                     st_tab[i] = tps_pkg::ST_NONE;
                     r.chg = 1'b1;
                  end
            end
         end
      endcase
      r.t = t;
      r.ns = (inr && o < DEPTH) ? st_tab[o] : tps_pkg::ST_NONE;
      r.idle = (fl_cnt == 0 && !window_scan(po, pw));
      return r;
   endfunction

   // ---------------------------------------------------------------- driver
   beat_type pending_beats [$];
   rsp_type  expected_rsp [$];
   bit       calm = 0;
   int       errors = 0;
   longint   cycles = 0;

   always @(posedge clock) begin : drive_req
      beat_type b;
      if (reset) begin
         req_valid <= 0;
      end else begin
         if (req_valid && req_ready) begin
            b = pending_beats.pop_front();
            expected_rsp.insert(expected_rsp.size(), schedule_event(b));
         end
         if (req_valid && !req_ready) begin
            // hold the beat until taken
         end else if (pending_beats.size() > 0 && (calm || $urandom_range(99) >= 34)) begin
            req_valid <= 1;
            req_cmd <= pending_beats[0].cmd;
            req_time_req <= pending_beats[0].t;
            req_outcome <= pending_beats[0].oc;
            req_on_disk <= pending_beats[0].disk;
         end else begin
            req_valid <= 0;
         end
      end
   end

   always @(posedge clock) begin
      rsp_ready <= calm || $urandom_range(99) >= 34;
   end

   // ---------------------------------------------------------------- monitor
   task automatic report(string what, logic [31:0] got, logic [31:0] want);
      $display("mismatch %s: got %0h want %0h at %0t", what, got, want, $realtime);
      errors++;
   endtask

   always @(posedge clock) begin : check_rsp
      rsp_type e;
      if (!reset && rsp_valid && rsp_ready) begin
         if (expected_rsp.size() == 0) begin
            report("unexpected beat", rsp_chosen_time, 32'd0);
         end else begin
            e = expected_rsp.pop_front();
            if (rsp_found !== e.found) report("found", 32'(rsp_found), 32'(e.found));
            if (rsp_chosen_time !== e.t) report("chosen_time", rsp_chosen_time, e.t);
            if (rsp_warm_only !== e.warm)
               report("warm_only", 32'(rsp_warm_only), 32'(e.warm));
            if (rsp_new_status !== e.ns)
               report("new_status", 32'(rsp_new_status), 32'(e.ns));
            if (rsp_status_changed !== e.chg)
               report("status_changed", 32'(rsp_status_changed), 32'(e.chg));
            if (rsp_idle !== e.idle) report("idle", 32'(rsp_idle), 32'(e.idle));
         end
      end
   end

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > CYCLE_LIMIT) begin
         $display("Regression FAIL");
         $finish;
      end
   end

   // ---------------------------------------------------------------- stimulus
   // random offset whose entry has the given status (or is in flight), -1 if none
   function automatic int find_off(logic [2:0] s, bit want_flight);
      int hits [$];
      u64_type sp;
      sp = series_on ? span_len() : 0;
      for (int i = 0; i < sp && i < DEPTH; i++)
         if (want_flight ? fl_m[i] : st_tab[i] == s) hits.insert(hits.size(), i);
      if (hits.size() == 0) return -1;
      return hits[$urandom_range(hits.size() - 1)];
   endfunction

   function automatic beat_type make_beat(logic [2:0] c, logic [1:0] oc, bit dk);
      beat_type b;
      int o;
      int unsigned r;
      u64_type sp;
      sp = span_len();
      b.cmd = c;
      b.oc = oc;
      b.disk = dk;
      o = -1;
      r = $urandom_range(9);
      case (c)
         tps_pkg::CMD_ISSUE:      o = find_off(tps_pkg::ST_QUEUED, 1'b0);
         tps_pkg::CMD_PF_DONE:    o = find_off(tps_pkg::ST_NONE, 1'b1);
         tps_pkg::CMD_EVICT_RAM:  o = find_off(tps_pkg::ST_RAM, 1'b0);
         tps_pkg::CMD_EVICT_DISK: o = find_off(tps_pkg::ST_DISK, 1'b0);
         tps_pkg::CMD_INT_DONE:   if (r < 6) o = int'(cur_off);
         default: ;
      endcase
      if (c == tps_pkg::CMD_PICK || c == tps_pkg::CMD_CANCEL || r == 0) b.t = $urandom;
      else if (o >= 0 && r != 1) b.t = cfg_first + 32'(o);
      else if (r == 1) b.t = cfg_first - 32'd1;
      else b.t = cfg_first + $urandom_range(0, 32'(sp + 1));
      return b;
   endfunction

   task automatic send(beat_type b);
      pending_beats.insert(pending_beats.size(), b);
      do @(negedge clock); while (pending_beats.size() != 0);
   endtask

   task automatic drain();
      do @(negedge clock); while (pending_beats.size() != 0 || expected_rsp.size() != 0);
      repeat (20) @(negedge clock);
   endtask

   task automatic set_series(logic [31:0] first, logic [31:0] last, logic pf, logic wrap,
                             logic [9:0] hist, logic [15:0] ram, logic [15:0] disk,
                             logic [6:0] mif);
      logic [31:0] vals [8];
      drain();
      vals = '{first, last, 32'(pf), 32'(wrap), 32'(hist), 32'(ram), 32'(disk), 32'(mif)};
      for (int i = 0; i < 8; i++) begin
         @(posedge clock);
         csr_we <= 1;
         csr_index <= 3'(i);
         csr_wdata <= vals[i];
         model_write(3'(i), vals[i]);
      end
      @(posedge clock);
      csr_we <= 0;
   endtask

   task automatic random_beats(int n);
      logic [2:0] c;
      int unsigned k;
      for (int i = 0; i < n; i++) begin
         k = $urandom_range(99);
         c = k < 10 ? tps_pkg::CMD_SEEK : k < 18 ? tps_pkg::CMD_INT_DONE :
             k < 42 ? tps_pkg::CMD_PICK : k < 60 ? tps_pkg::CMD_ISSUE :
             k < 76 ? tps_pkg::CMD_PF_DONE : k < 85 ? tps_pkg::CMD_EVICT_RAM :
             k < 91 ? tps_pkg::CMD_EVICT_DISK : k < 93 ? tps_pkg::CMD_CANCEL :
             3'($urandom);
         // issue outcomes mostly submit so that loads get in flight
         send(make_beat(c, (c == tps_pkg::CMD_ISSUE && $urandom_range(9) < 6) ?
                           tps_pkg::OC_SUBMIT : 2'($urandom),
                        1'($urandom_range(1))));
      end
   endtask

   initial begin
      cfg_first = 0; cfg_last = 0; cfg_pf = 0; cfg_wrap = 0;
      cfg_hist = 0; cfg_ram = 0; cfg_disk = 0; cfg_mif = 1;
      clear_series();
      series_on = 1'b0;
      repeat (10) @(posedge clock);
      reset <= 0;

      // no series yet: everything but cancel all is ignored
      send(make_beat(tps_pkg::CMD_SEEK, tps_pkg::OC_OK, 1'b0));
      send(make_beat(tps_pkg::CMD_PICK, tps_pkg::OC_OK, 1'b0));
      send(make_beat(tps_pkg::CMD_CANCEL, tps_pkg::OC_OK, 1'b0));

      // directed: each command with each outcome on a small series
      set_series(32'd100, 32'd115, 1'b1, 1'b0, 10'd0, 16'd6, 16'd12, 7'd2);
      for (int c = 0; c < 8; c++)
         for (int oc = 0; oc < 4; oc++) begin
            if (c == tps_pkg::CMD_ISSUE)
               send(make_beat(tps_pkg::CMD_PICK, tps_pkg::OC_OK, 1'b0));
            send(make_beat(3'(c), 2'(oc), oc[0]));
         end

      random_beats(70);
      // top of the 32-bit range, wrapping windows
      set_series(32'hFFFF_FFF0, 32'hFFFF_FFFF, 1'b1, 1'b1, 10'd1, 16'd5, 16'd14, 7'd3);
      random_beats(70);
      // single-entry series (last below first)
      set_series(32'd1000, 32'd999, 1'b1, 1'b0, 10'd0, 16'd4, 16'd4, 7'd1);
      random_beats(20);
      // budgets at zero, disk tier off
      set_series(32'd5000, 32'd5031, 1'b1, 1'b0, 10'd0, 16'd0, 16'd0, 7'd4);
      random_beats(40);
      // no idling on either side
      calm = 1;
      set_series(32'd7, 32'd60, 1'b1, 1'b1, 10'd1023, 16'hFFFF, 16'hFFFF, 7'd64);
      random_beats(70);
      calm = 0;
      // prefetch off
      set_series(32'd0, 32'd20, 1'b0, 1'b0, 10'd2, 16'd8, 16'd16, 7'd2);
      random_beats(30);
      // full depth, clamped last
      set_series(32'd0, 32'hFFFF_FFFF, 1'b1, 1'b0, 10'd3, 16'd40, 16'd80, 7'd8);
      random_beats(25);
      for (int p = 0; p < 5; p++) begin
         logic [31:0] f;
         f = $urandom;
         set_series(f, f + $urandom_range(1, 40), 1'b1, 1'($urandom_range(1)),
                    10'($urandom_range(0, 6)), 16'($urandom_range(1, 30)),
                    16'($urandom_range(0, 60)), 7'($urandom_range(1, 64)));
         random_beats(50);
      end

      drain();
      repeat (100) @(negedge clock);
      if (errors == 0) begin
         $display("Regression PASS");
      end else begin
         $display("Regression FAIL");
      end
      $finish;
   end

endmodule
